// ===== sv/drle_pkg.sv =====
package drle_pkg;

  // Default frame size in bytes; the top level hands it down as FRAME_BYTES.
  localparam int unsigned DRLE_FRAME_BYTES = 512;

  // Bit of a header byte that marks a repeat run.
  localparam int unsigned REPEAT_FLAG_BIT = 7;

  // Decoder phase codes.
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_REPEAT  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       packet_first;
    logic       packet_last;
    logic [9:0] out_capacity;
  } drle_item_t;

  typedef struct packed {
    logic [8:0] write_pos;
    logic [7:0] fill_value;
    logic [6:0] run_length;
    logic [9:0] total_written;
    logic       is_last;
  } drle_result_t;

endpackage

// ===== sv/drle_in_reg.sv =====
module drle_in_reg import drle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  drle_item_t item_i,
  input  logic       advance_i,
  output logic       stall_o,
  output logic       vld_o,
  output drle_item_t item_o
);

  logic       vld_q, vld_d;
  drle_item_t item_q;
  logic       accept;

  // A held item that cannot move on blocks the next request.
  assign stall_o = vld_q && !advance_i;
  assign accept  = in_valid_i && !stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== sv/drle_engine.sv =====
module drle_engine import drle_pkg::*; #(
  parameter int unsigned FRAME_BYTES = DRLE_FRAME_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_vld_i,
  input  drle_item_t   item_i,
  input  logic         out_free_i,
  output logic         advance_o,
  output logic         res_load_o,
  output drle_result_t res_o
);

  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned XW = (CW > 10) ? CW : 10;

  logic [1:0]    phase_q, phase_d;
  logic [6:0]    pend_q, pend_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] cap_q, cap_d;

  logic [1:0]    phase_x;
  logic [6:0]    pend_x;
  logic [XW-1:0] pos_x, cap_x, cap_in_x, frame_x, cnt_x, pos_n_x, cap_n_x;
  logic [6:0]    run;
  logic          produce;
  logic [CW:0]   pc_sum;

  always_comb begin
    cap_in_x = XW'(item_i.out_capacity);
    frame_x  = XW'(FRAME_BYTES);

    // The first byte of a packet restarts the decoder before it is decoded.
    if (item_i.packet_first) begin
      phase_x = PH_HEADER;
      pend_x  = '0;
      pos_x   = '0;
      cap_x   = (cap_in_x > frame_x) ? frame_x : cap_in_x;
    end else begin
      phase_x = phase_q;
      pend_x  = pend_q;
      pos_x   = XW'(pos_q);
      cap_x   = XW'(cap_q);
    end

    cnt_x = XW'(item_i.coded_byte[6:0]);
    if (cnt_x > cap_x) begin
      cnt_x = cap_x;
    end

    phase_d = phase_x;
    pend_d  = pend_x;
    run     = '0;
    if (cap_x != '0) begin
      unique case (phase_x)
        PH_REPEAT: begin
          run     = pend_x;
          phase_d = PH_HEADER;
          pend_d  = '0;
        end
        PH_LITERAL: begin
          run    = 7'd1;
          pend_d = pend_x - 7'd1;
          if (pend_d == '0) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          pend_d = cnt_x[6:0];
          if (item_i.coded_byte[REPEAT_FLAG_BIT]) begin
            phase_d = PH_REPEAT;
          end else if (cnt_x != '0) begin
            phase_d = PH_LITERAL;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      endcase
    end

    produce = (run != '0);
    pos_n_x = pos_x + XW'(run);
    cap_n_x = cap_x - XW'(run);

    pos_d = pos_n_x[CW-1:0];
    cap_d = cap_n_x[CW-1:0];
    // After the last byte of a packet everything is ignored until the next one.
    if (item_i.packet_last) begin
      cap_d   = '0;
      phase_d = PH_HEADER;
      pend_d  = '0;
    end

    res_o.write_pos     = pos_x[8:0];
    res_o.fill_value    = item_i.coded_byte;
    res_o.run_length    = run;
    res_o.total_written = pos_n_x[9:0];
    res_o.is_last       = (cap_n_x == '0) || item_i.packet_last;
  end

  assign advance_o  = item_vld_i && (!produce || out_free_i);
  assign res_load_o = advance_o && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pend_q  <= '0;
      pos_q   <= '0;
      cap_q   <= '0;
    end else if (advance_o) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      cap_q   <= cap_d;
    end
  end

  assign pc_sum = {1'b0, pos_q} + {1'b0, cap_q};

  a_spent_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q == '0) |-> (phase_q == PH_HEADER && pend_q == '0))
    else $error("decoder holds a pending run with no capacity left");

  a_pend_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(pend_q) <= cap_q) || (CW < 7 && XW'(pend_q) <= XW'(cap_q)))
    else $error("pending count exceeds remaining capacity");

  a_literal_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LITERAL) |-> (pend_q != '0))
    else $error("literal phase with nothing owed");

  a_frame_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_sum <= (CW + 1)'(FRAME_BYTES))
    else $error("position plus capacity exceeds the frame");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_i && !advance_o) |=> $stable(phase_q) && $stable(pos_q))
    else $error("decoder state moved without a request advancing");

endmodule

// ===== sv/drle_out_reg.sv =====
module drle_out_reg import drle_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  drle_result_t res_i,
  input  logic         stall_i,
  output logic         free_o,
  output logic         valid_o,
  output drle_result_t res_o
);

  logic         vld_q, vld_d;
  drle_result_t res_q;

  // The register can take a new result when empty or when its request leaves now.
  assign free_o = !vld_q || !stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (free_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

// ===== sv/dmx_rle_decoder_core.sv =====
// A write command reaches the outputs once its coded byte, held in the input register,
// is decoded and loaded into the result register when that register is free.
// Throughput: one coded byte per cycle while out_stall_i holds back no write; the input
// register, the decode logic and the result register form a two-stage pipeline with one
// state update per byte. A byte producing no write never waits on the result register.
// Reset (rst_ni low, asynchronous) empties both registers, sets the decoder to
// expect a header and zeroes the capacity, so bytes are ignored until packet_first.
module dmx_rle_decoder_core import drle_pkg::*; #(
  parameter int unsigned FRAME_BYTES = DRLE_FRAME_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] coded_byte_i,
  input  logic       packet_first_i,
  input  logic       packet_last_i,
  input  logic [9:0] out_capacity_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [8:0] write_pos_o,
  output logic [7:0] fill_value_o,
  output logic [6:0] run_length_o,
  output logic [9:0] total_written_o,
  output logic       is_last_o
);

  drle_item_t   in_item, held_item;
  drle_result_t eng_res, out_res;
  logic         held_vld, advance, res_load, out_free;

  assign in_item.coded_byte   = coded_byte_i;
  assign in_item.packet_first = packet_first_i;
  assign in_item.packet_last  = packet_last_i;
  assign in_item.out_capacity = out_capacity_i;

  drle_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (in_item),
    .advance_i  (advance),
    .stall_o    (in_stall_o),
    .vld_o      (held_vld),
    .item_o     (held_item)
  );

  drle_engine #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (held_vld),
    .item_i     (held_item),
    .out_free_i (out_free),
    .advance_o  (advance),
    .res_load_o (res_load),
    .res_o      (eng_res)
  );

  drle_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (eng_res),
    .stall_i (out_stall_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign write_pos_o     = out_res.write_pos;
  assign fill_value_o    = out_res.fill_value;
  assign run_length_o    = out_res.run_length;
  assign total_written_o = out_res.total_written;
  assign is_last_o       = out_res.is_last;

endmodule
